// ===== src/qcv_pkg.sv =====
// qcv_pkg: shared widths, codes, sequencer states and saturation helper
// for the quadrature counter with velocity. No dependencies.
package qcv_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int RPC_W       = 32;
  localparam int TIME_W      = 32;
  localparam int OUT_W       = 32;

  // count magnitude times rad_per_count
  localparam int PROD_W   = COUNT_WIDTH + RPC_W;
  // product times 1000 plus the rounding term
  localparam int VNUM_W   = PROD_W + 10;
  localparam int VSH_W    = VNUM_W - 12;
  localparam int VHI_W    = VSH_W - 32;
  localparam int HI_CMP_W = (VHI_W > 32) ? VHI_W : 32;
  localparam int PSH_W    = PROD_W + 1 - 12;

  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [RPC_W-1:0]  RPC_RESET = 32'd1647099;
  localparam logic [PROD_W:0]   POS_ROUND = (PROD_W + 1)'(2048);
  localparam logic [OUT_W-1:0]  POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0]  NEG_LIMIT = 32'h8000_0000;

  localparam logic [1:0] MODE_A   = 2'd0;
  localparam logic [1:0] MODE_B   = 2'd1;
  localparam logic [1:0] MODE_VEL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VPREP,
    ST_VMUL,
    ST_VSCALE,
    ST_VDIVS,
    ST_VDIVW,
    ST_PPREP,
    ST_PMUL,
    ST_PRND,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  // clamp a magnitude to the signed range and apply the sign
  function automatic logic [OUT_W-1:0] sat_apply(input logic ovf,
                                                 input logic [OUT_W-1:0] q,
                                                 input logic neg);
    logic [OUT_W-1:0] lim;
    logic [OUT_W-1:0] qs;
    lim = neg ? NEG_LIMIT : POS_LIMIT;
    qs  = (ovf || (q > lim)) ? lim : q;
    return neg ? (~qs + 1'b1) : qs;
  endfunction

endpackage

// ===== src/qcv_mul.sv =====
// qcv_mul: registered unsigned multiplier shared by the position and
// velocity paths. Depends on qcv_pkg.
module qcv_mul (
  input  logic                           clk,
  input  logic [qcv_pkg::COUNT_WIDTH-1:0] a,
  input  logic [qcv_pkg::RPC_W-1:0]       b,
  output logic [qcv_pkg::PROD_W-1:0]      p
);

  always_ff @(posedge clk) begin
    p <= qcv_pkg::PROD_W'(a) * qcv_pkg::PROD_W'(b);
  end

endmodule

// ===== src/qcv_div.sv =====
// qcv_div: restoring divider, one quotient bit per cycle, with an early
// overflow flag when the quotient would not fit 32 bits. Depends on qcv_pkg.
module qcv_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [qcv_pkg::VHI_W-1:0]  num_hi,
  input  logic [31:0]                num_lo,
  input  logic [31:0]                divisor,
  output logic [31:0]                quotient,
  output qcv_pkg::div_stat_t         stat
);

  logic                              busy;
  logic                              done;
  logic                              ovf;
  logic [qcv_pkg::DIV_CNT_W-1:0]     cnt;
  logic [31:0]                       rem;
  logic [31:0]                       num;
  logic [32:0]                       trial;
  logic [32:0]                       diff;
  logic                              fits;
  logic [qcv_pkg::HI_CMP_W-1:0]      hi_ext;
  logic                              start_ovf;

  assign hi_ext    = qcv_pkg::HI_CMP_W'(num_hi);
  assign start_ovf = hi_ext >= qcv_pkg::HI_CMP_W'(divisor);
  assign stat      = {done, ovf};

  always_comb begin
    trial = {rem, num[31]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= !start_ovf;
        done <= start_ovf;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ovf      <= start_ovf;
      rem      <= hi_ext[31:0];
      num      <= num_lo;
      quotient <= '0;
      cnt      <= qcv_pkg::DIV_CNT_W'(qcv_pkg::DIV_STEPS - 1);
    end else if (busy) begin
      num      <= {num[30:0], 1'b0};
      rem      <= fits ? diff[31:0] : trial[31:0];
      quotient <= {quotient[30:0], fits};
      cnt      <= cnt - 1'b1;
    end
  end

endmodule

// ===== src/quadrature_counter_with_velocity_unit.sv =====
// quadrature_counter_with_velocity_unit: x4 edge counter with angle and speed
// in fixed point. Depends on qcv_pkg, qcv_mul and qcv_div.
//
//   channel  dir  payload                                           done when
//   cfg      in   cfg_wr_data = rad_per_count (Q4.28)               cfg_wr_en
//   s_*      in   tuser = mode; tdata = level_a, level_b, now_ms    tvalid & tready
//   m_*      out  tdata = count, position, velocity, velocity_valid tvalid & tready
//
// An edge item goes from transfer to result through count update, operand
// prep, one pass through the shared multiplier, rounding and output load.
// A velocity sample adds a multiply, a scale by 1000 and a wait on the
// bit-serial divider (32 steps plus its done flag) ahead of the position pass.
// A sample with zero elapsed time skips the multiply, scale and divide.
// s_tready is high only while the sequencer is idle; one item at a time.
// The result sits in an output register, so a stalled m_tready holds only the
// next result, not the next transfer in.
// rst is synchronous: counts, times and velocity clear, rad_per_count returns
// to its reset value, and no result is pending.
module quadrature_counter_with_velocity_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [31:0]  cfg_wr_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // level_a[0], level_b[1], now_ms[33:2], zero pad
  input  logic [1:0]   s_tuser,   // mode[1:0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata    // count[31:0], position[63:32], velocity[95:64],
                                  // velocity_valid[96], zero pad
);

  localparam int CW = qcv_pkg::COUNT_WIDTH;

  qcv_pkg::state_t state, state_next;

  logic [qcv_pkg::RPC_W-1:0]  rad_per_count;
  logic [CW-1:0]              edge_count;
  logic [CW-1:0]              last_sample_count;
  logic [qcv_pkg::TIME_W-1:0] last_sample_time;
  logic [qcv_pkg::OUT_W-1:0]  last_velocity;
  logic                       last_valid;

  logic [qcv_pkg::TIME_W-1:0] now_ms;
  logic [qcv_pkg::TIME_W-1:0] dt;
  logic [CW-1:0]              op_mag;
  logic                       op_neg;
  logic [qcv_pkg::VSH_W-1:0]  vsh;
  logic [qcv_pkg::OUT_W-1:0]  position;

  logic                       accept;
  logic                       step_up;
  logic                       out_free;
  logic [CW-1:0]              delta;
  logic [CW-1:0]              src;
  logic                       src_neg;
  logic [CW-1:0]              src_mag;
  logic [qcv_pkg::TIME_W-1:0] dt_new;
  logic [qcv_pkg::PROD_W-1:0] prod;
  logic [qcv_pkg::VNUM_W-1:0] pe;
  logic [qcv_pkg::VNUM_W-1:0] vnum;
  logic [qcv_pkg::PROD_W:0]   psum;
  logic [qcv_pkg::PSH_W-1:0]  psh;
  logic                       povf;
  logic signed [63:0]         count_sx;

  logic                       div_start;
  logic [31:0]                div_quo;
  qcv_pkg::div_stat_t         div_stat;

  assign s_tready = (state == qcv_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // direction of one x4 step
  assign step_up = (s_tuser == qcv_pkg::MODE_A) ? (s_tdata[0] != s_tdata[1])
                                                 : (s_tdata[0] == s_tdata[1]);

  // operand for the shared multiplier: delta during the velocity prep, else count
  assign delta   = edge_count - last_sample_count;
  assign src     = (state == qcv_pkg::ST_VPREP) ? delta : edge_count;
  assign src_neg = src[CW-1];
  assign src_mag = src_neg ? (~src + 1'b1) : src;
  assign dt_new  = now_ms - last_sample_time;

  qcv_mul u_mul (
    .clk (clk),
    .a   (op_mag),
    .b   (rad_per_count),
    .p   (prod)
  );

  // times 1000 as 1024 - 16 - 8, plus half the divisor, then drop the 2^12 scale
  assign pe   = qcv_pkg::VNUM_W'(prod);
  assign vnum = (pe << 10) - (pe << 4) - (pe << 3) + (qcv_pkg::VNUM_W'(dt) << 11);

  // position rounding: add half an LSB of Q15.16 and drop 12 bits
  assign psum = (qcv_pkg::PROD_W + 1)'(prod) + qcv_pkg::POS_ROUND;
  assign psh  = psum[qcv_pkg::PROD_W:12];
  assign povf = |psh[qcv_pkg::PSH_W-1:32];

  assign div_start = (state == qcv_pkg::ST_VDIVS);

  qcv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num_hi   (vsh[qcv_pkg::VSH_W-1:32]),
    .num_lo   (vsh[31:0]),
    .divisor  (dt),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  assign count_sx = 64'(signed'(edge_count));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qcv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      qcv_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (s_tuser == qcv_pkg::MODE_VEL) ? qcv_pkg::ST_VPREP
                                                       : qcv_pkg::ST_PPREP;
        end
      end
      qcv_pkg::ST_VPREP: begin
        state_next = (dt_new == '0) ? qcv_pkg::ST_PPREP : qcv_pkg::ST_VMUL;
      end
      qcv_pkg::ST_VMUL:   state_next = qcv_pkg::ST_VSCALE;
      qcv_pkg::ST_VSCALE: state_next = qcv_pkg::ST_VDIVS;
      qcv_pkg::ST_VDIVS:  state_next = qcv_pkg::ST_VDIVW;
      qcv_pkg::ST_VDIVW: begin
        if (div_stat.done) begin
          state_next = qcv_pkg::ST_PPREP;
        end
      end
      qcv_pkg::ST_PPREP:  state_next = qcv_pkg::ST_PMUL;
      qcv_pkg::ST_PMUL:   state_next = qcv_pkg::ST_PRND;
      qcv_pkg::ST_PRND:   state_next = qcv_pkg::ST_FIN;
      qcv_pkg::ST_FIN: begin
        if (out_free) begin
          state_next = qcv_pkg::ST_IDLE;
        end
      end
      default: state_next = qcv_pkg::ST_IDLE;
    endcase
  end

  // architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      rad_per_count     <= qcv_pkg::RPC_RESET;
      edge_count        <= '0;
      last_sample_count <= '0;
      last_sample_time  <= '0;
      last_velocity     <= '0;
      last_valid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rad_per_count <= cfg_wr_data;
      end
      // advance or step back on an edge; velocity samples and the unused mode leave it
      if (accept) begin
        case (s_tuser)
          qcv_pkg::MODE_A, qcv_pkg::MODE_B: begin
            edge_count <= step_up ? (edge_count + 1'b1) : (edge_count - 1'b1);
          end
          default: ;
        endcase
      end
      // a sample always stores its time and count; delta is captured already
      if (state == qcv_pkg::ST_VPREP) begin
        last_sample_time  <= now_ms;
        last_sample_count <= edge_count;
        if (dt_new == '0) begin
          last_velocity <= '0;
          last_valid    <= 1'b0;
        end
      end
      if ((state == qcv_pkg::ST_VDIVW) && div_stat.done) begin
        last_velocity <= qcv_pkg::sat_apply(div_stat.ovf, div_quo, op_neg);
        last_valid    <= 1'b1;
      end
    end
  end

  // datapath holding registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now_ms <= s_tdata[33:2];
    end
    if ((state == qcv_pkg::ST_VPREP) || (state == qcv_pkg::ST_PPREP)) begin
      op_mag <= src_mag;
      op_neg <= src_neg;
    end
    if (state == qcv_pkg::ST_VPREP) begin
      dt <= dt_new;
    end
    if (state == qcv_pkg::ST_VSCALE) begin
      vsh <= vnum[qcv_pkg::VNUM_W-1:12];
    end
    if (state == qcv_pkg::ST_PRND) begin
      position <= qcv_pkg::sat_apply(povf, psh[31:0], op_neg);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == qcv_pkg::ST_FIN) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == qcv_pkg::ST_FIN) && out_free) begin
      m_tdata <= {7'b0, last_valid, last_velocity, position, count_sx[31:0]};
    end
  end

  // one item in flight: no second transfer right behind the first
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second input transfer taken while an item is in work");

  // an edge moves the count by exactly one
  a_edge_step: assert property (@(posedge clk) disable iff (rst)
    (accept && ((s_tuser == qcv_pkg::MODE_A) || (s_tuser == qcv_pkg::MODE_B)))
    |=> ((edge_count == $past(edge_count) + 1'b1) ||
         (edge_count == $past(edge_count) - 1'b1)))
    else $error("edge item did not move the count by one");

  // the divider reports only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == qcv_pkg::ST_VDIVW))
    else $error("divider finished outside its wait state");

  // a finished item always leaves a result on the output
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    ((state == qcv_pkg::ST_FIN) && out_free) |=> (m_tvalid && s_tready))
    else $error("finished item did not reach the output register");

endmodule
